/* hw/rtl/tdr_pkg.sv */
// tdr_pkg: shared types, widths and codes for the differential text display refresh.
// Used by tdr_front, tdr_back and the top level text_display_diff_refresh.
// No dependencies.
`timescale 1ns / 1ps

package tdr_pkg;

	// Grid size defaults
	localparam int DEF_ROWS = 4;
	localparam int DEF_COLS = 16;

	// Internal counter widths, sized to cover ROWS up to 8 and COLS up to 40
	// as well as the unclipped region ends row+height and col+width
	localparam int ROW_CNT_W = 4;
	localparam int COL_CNT_W = 6;
	localparam int EQ_W      = 5;
	localparam int CHAR_W    = 8;

	// Configuration register widths and indexes
	localparam int GOTO_W     = 4;
	localparam int DROWS_W    = 3;
	localparam int DCOLS_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_TOL      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_COLS = 2'd2;

	localparam logic [GOTO_W-1:0]  GOTO_RESET  = 4'd0;
	localparam logic [DROWS_W-1:0] DROWS_RESET = 3'd4;
	localparam logic [DCOLS_W-1:0] DCOLS_RESET = 5'd16;

	// Command modes
	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_FORCE   = 2'd1;
	localparam logic [1:0] MODE_REFRESH = 2'd2;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	// Decoded operation
	typedef enum logic [1:0] {
		OP_NOP,
		OP_WR_WANTED,
		OP_WR_SHOWN,
		OP_REFRESH
	} tdr_op_t;

	// Input item
	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] row;
		logic [3:0] col;
		logic [7:0] char_in;
		logic [2:0] height;
		logic [4:0] width;
	} tdr_cmd_t;

	// Result item
	typedef struct packed {
		logic [1:0] out_row;
		logic [3:0] out_col;
		logic [7:0] char_out;
		logic       run_start;
		logic       last;
	} tdr_result_t;

	// Classified command held in the queue
	typedef struct packed {
		tdr_op_t                op;
		logic [ROW_CNT_W-1:0]   row;
		logic [COL_CNT_W-1:0]   col;
		logic [CHAR_W-1:0]      data;
		logic [ROW_CNT_W-1:0]   rlim;
		logic [COL_CNT_W-1:0]   clim;
	} tdr_entry_t;

	// Queue head toward the back end
	typedef struct packed {
		logic       valid;
		tdr_entry_t entry;
	} tdr_fwd_t;

	// Back end status toward the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} tdr_bstat_t;

endpackage

/* hw/rtl/tdr_front.sv */
// tdr_front: command intake, configuration registers, classification and clipping,
// and the short command queue feeding the back end.
// Depends on tdr_pkg.
`timescale 1ns / 1ps

module tdr_front #(
	parameter int ROWS = tdr_pkg::DEF_ROWS,
	parameter int COLS = tdr_pkg::DEF_COLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  tdr_pkg::tdr_cmd_t                cmd,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  tdr_pkg::tdr_bstat_t              bstat,
	output tdr_pkg::tdr_fwd_t                fwd,
	output logic [tdr_pkg::GOTO_W-1:0]       gap_tol
);
	import tdr_pkg::*;

	logic [DROWS_W-1:0]   display_rows_q;
	logic [DCOLS_W-1:0]   display_cols_q;
	logic [GOTO_W-1:0]    gap_tol_q;

	tdr_entry_t           q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	tdr_entry_t           entry;
	logic [ROW_CNT_W-1:0] row_end;
	logic [COL_CNT_W-1:0] col_end;
	logic                 in_grid;
	logic                 q_full;
	logic                 push;

	assign cfg_ready = 1'b1;
	assign gap_tol   = gap_tol_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_tol_q      <= GOTO_RESET;
			display_rows_q <= DROWS_RESET;
			display_cols_q <= DCOLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAP_TOL:      gap_tol_q      <= cfg_data[GOTO_W-1:0];
				REG_DISPLAY_ROWS: display_rows_q <= cfg_data[DROWS_W-1:0];
				REG_DISPLAY_COLS: display_cols_q <= cfg_data[DCOLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Region clipping: smallest of region end, grid size and display size
	always_comb begin
		row_end = ROW_CNT_W'(cmd.row) + ROW_CNT_W'(cmd.height);
		if (row_end > ROW_CNT_W'(ROWS))
			row_end = ROW_CNT_W'(ROWS);
		if (row_end > ROW_CNT_W'(display_rows_q))
			row_end = ROW_CNT_W'(display_rows_q);
		col_end = COL_CNT_W'(cmd.col) + COL_CNT_W'(cmd.width);
		if (col_end > COL_CNT_W'(COLS))
			col_end = COL_CNT_W'(COLS);
		if (col_end > COL_CNT_W'(display_cols_q))
			col_end = COL_CNT_W'(display_cols_q);
	end

	// Classification
	assign in_grid = (ROW_CNT_W'(cmd.row) < ROW_CNT_W'(ROWS)) &&
			(COL_CNT_W'(cmd.col) < COL_CNT_W'(COLS));

	always_comb begin
		entry.row  = ROW_CNT_W'(cmd.row);
		entry.col  = COL_CNT_W'(cmd.col);
		entry.rlim = row_end;
		entry.clim = col_end;
		entry.data = cmd.char_in;
		case (cmd.mode)
			MODE_WRITE:   entry.op = in_grid ? OP_WR_WANTED : OP_NOP;
			MODE_FORCE: begin
				entry.op   = in_grid ? OP_WR_SHOWN : OP_NOP;
				entry.data = ~cmd.char_in;
			end
			MODE_REFRESH: entry.op = OP_REFRESH;
			default:      entry.op = OP_NOP;
		endcase
	end

	assign q_full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign busy   = q_full || bstat.clearing;
	// Ignored commands are taken but never queued
	assign push   = start && !busy && (entry.op != OP_NOP);

	// Command queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (bstat.pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !bstat.pop)
				count_q <= count_q + 1'b1;
			else if (!push && bstat.pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Command queue storage
	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= entry;
	end

	assign fwd.valid = (count_q != '0);
	assign fwd.entry = q_mem_q[rd_ptr_q];

	// Queue checks
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
			bstat.pop |-> count_q != '0)
		else $error("tdr_front: pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("tdr_front: queue count overflow");
	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
			bstat.clearing |-> busy && !push)
		else $error("tdr_front: command queued during clear");

endmodule

/* hw/rtl/tdr_back.sv */
// tdr_back: executes queued commands on the wanted and shadow character memories,
// scans refresh regions for runs and emits the result stream.
// Depends on tdr_pkg.
`timescale 1ns / 1ps

module tdr_back #(
	parameter int ROWS = tdr_pkg::DEF_ROWS,
	parameter int COLS = tdr_pkg::DEF_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdr_pkg::tdr_fwd_t             fwd,
	output tdr_pkg::tdr_bstat_t           bstat,
	input  logic [tdr_pkg::GOTO_W-1:0]    gap_tol,
	output logic                          result_valid,
	output tdr_pkg::tdr_result_t          result
);
	import tdr_pkg::*;

	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ROW,
		S_SCAN,
		S_EMIT,
		S_FLUSH
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_CNT_W-1:0] r,
			input logic [COL_CNT_W-1:0] c);
		cell_addr = ADDR_W'(int'(r) * COLS + int'(c));
	endfunction

	logic [CHAR_W-1:0]    wanted_mem [CELLS];
	logic [CHAR_W-1:0]    shown_mem  [CELLS];
	logic [CHAR_W-1:0]    wanted_rd_q;
	logic [CHAR_W-1:0]    shown_rd_q;

	state_t               state_q;
	logic [ADDR_W-1:0]    clr_q;
	tdr_entry_t           cmd_q;
	logic [ROW_CNT_W-1:0] r_q;
	logic [COL_CNT_W-1:0] issue_c_q;
	logic                 run_q;
	logic [COL_CNT_W-1:0] p1_q;
	logic [COL_CNT_W-1:0] p2_q;
	logic [EQ_W-1:0]      eq_q;
	logic [COL_CNT_W-1:0] resume_q;
	logic [COL_CNT_W-1:0] k_q;
	logic                 cmp_v_s1;
	logic [COL_CNT_W-1:0] cmp_c_s1;
	logic                 emit_v_s1;
	logic [COL_CNT_W-1:0] emit_c_s1;
	logic                 emit_first_s1;
	tdr_result_t          pend_q;
	logic                 pend_v_q;
	logic                 result_valid_q;
	tdr_result_t          result_q;

	logic                 pop;
	logic                 clearing;
	logic                 differ;
	logic [EQ_W-1:0]      eq_next;
	logic [ADDR_W-1:0]    pop_addr;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 wanted_we;
	logic [ADDR_W-1:0]    wanted_wa;
	logic [CHAR_W-1:0]    wanted_wd;
	logic                 shown_we;
	logic [ADDR_W-1:0]    shown_wa;
	logic [CHAR_W-1:0]    shown_wd;
	tdr_result_t          new_res;

	assign clearing = (state_q == S_CLEAR);
	assign pop      = fwd.valid && (state_q == S_IDLE);
	assign bstat.pop      = pop;
	assign bstat.clearing = clearing;

	assign differ   = (wanted_rd_q != shown_rd_q);
	assign eq_next  = eq_q + 1'b1;
	assign pop_addr = cell_addr(fwd.entry.row, fwd.entry.col);
	assign rd_addr  = (state_q == S_EMIT) ? cell_addr(r_q, k_q) : cell_addr(r_q, issue_c_q);

	// Memory write ports: clear sweep, direct cell writes, shadow update on emit
	always_comb begin
		wanted_we = clearing || (pop && fwd.entry.op == OP_WR_WANTED);
		wanted_wa = clearing ? clr_q : pop_addr;
		wanted_wd = clearing ? BLANK_CHAR : fwd.entry.data;
		shown_we  = clearing || emit_v_s1 || (pop && fwd.entry.op == OP_WR_SHOWN);
		if (clearing) begin
			shown_wa = clr_q;
			shown_wd = BLANK_CHAR;
		end else if (emit_v_s1) begin
			shown_wa = cell_addr(r_q, emit_c_s1);
			shown_wd = wanted_rd_q;
		end else begin
			shown_wa = pop_addr;
			shown_wd = fwd.entry.data;
		end
	end

	// Wanted character memory
	always_ff @(posedge clk) begin
		if (wanted_we)
			wanted_mem[wanted_wa] <= wanted_wd;
		wanted_rd_q <= wanted_mem[rd_addr];
	end

	// Shadow memory
	always_ff @(posedge clk) begin
		if (shown_we)
			shown_mem[shown_wa] <= shown_wd;
		shown_rd_q <= shown_mem[rd_addr];
	end

	// Result carried by an emitted cell
	always_comb begin
		new_res.out_row   = r_q[1:0];
		new_res.out_col   = emit_c_s1[3:0];
		new_res.char_out  = wanted_rd_q;
		new_res.run_start = emit_first_s1;
		new_res.last      = 1'b0;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			cmd_q          <= '0;
			r_q            <= '0;
			issue_c_q      <= '0;
			run_q          <= 1'b0;
			p1_q           <= '0;
			p2_q           <= '0;
			eq_q           <= '0;
			resume_q       <= '0;
			k_q            <= '0;
			cmp_v_s1       <= 1'b0;
			cmp_c_s1       <= '0;
			emit_v_s1      <= 1'b0;
			emit_c_s1      <= '0;
			emit_first_s1  <= 1'b0;
			pend_q         <= '0;
			pend_v_q       <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;

			// A finished cell pushes out the one held before it
			if (emit_v_s1) begin
				if (pend_v_q) begin
					result_valid_q <= 1'b1;
					result_q       <= pend_q;
				end
				pend_q   <= new_res;
				pend_v_q <= 1'b1;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1))
						state_q <= S_IDLE;
				end

				S_IDLE: begin
					if (pop) begin
						cmd_q <= fwd.entry;
						r_q   <= fwd.entry.row;
						if (fwd.entry.op == OP_REFRESH)
							state_q <= S_ROW;
					end
				end

				S_ROW: begin
					if (r_q < cmd_q.rlim) begin
						issue_c_q <= cmd_q.col;
						run_q     <= 1'b0;
						state_q   <= S_SCAN;
					end else begin
						state_q <= S_FLUSH;
					end
				end

				S_SCAN: begin
					// Read one cell a cycle while scanning; compare each read in the following cycle
					if (issue_c_q < cmd_q.clim) begin
						cmp_v_s1  <= 1'b1;
						cmp_c_s1  <= issue_c_q;
						issue_c_q <= issue_c_q + 1'b1;
					end else begin
						cmp_v_s1 <= 1'b0;
					end

					if (cmp_v_s1) begin
						if (!run_q) begin
							if (differ) begin
								run_q <= 1'b1;
								p1_q  <= cmp_c_s1;
								p2_q  <= cmp_c_s1;
								eq_q  <= '0;
							end
						end else if (differ) begin
							p2_q <= cmp_c_s1;
							eq_q <= '0;
						end else if (eq_next > EQ_W'(gap_tol)) begin
							// Gap too long: close the run, drop the read in flight
							cmp_v_s1 <= 1'b0;
							resume_q <= cmp_c_s1 + 1'b1;
							k_q      <= p1_q;
							state_q  <= S_EMIT;
						end else begin
							eq_q <= eq_next;
						end
					end else if (issue_c_q >= cmd_q.clim) begin
						// End of row
						if (run_q) begin
							resume_q <= issue_c_q;
							k_q      <= p1_q;
							state_q  <= S_EMIT;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= S_ROW;
						end
					end
				end

				S_EMIT: begin
					if (k_q <= p2_q) begin
						emit_v_s1     <= 1'b1;
						emit_c_s1     <= k_q;
						emit_first_s1 <= (k_q == p1_q);
						k_q           <= k_q + 1'b1;
					end else begin
						emit_v_s1 <= 1'b0;
						if (!emit_v_s1) begin
							issue_c_q <= resume_q;
							run_q     <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end

				S_FLUSH: begin
					if (pend_v_q) begin
						result_valid_q <= 1'b1;
						result_q       <= pend_q;
						result_q.last  <= 1'b1;
						pend_v_q       <= 1'b0;
					end
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Sequencer checks
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
			emit_v_s1 |-> (emit_c_s1 <= p2_q) && (state_q == S_EMIT))
		else $error("tdr_back: emitted cell outside run");
	a_emit_no_cmp: assert property (@(posedge clk) disable iff (!arst_n)
			state_q == S_EMIT |-> !cmp_v_s1)
		else $error("tdr_back: compare pending during emit");
	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
			cmp_v_s1 |-> cmp_c_s1 < cmd_q.clim)
		else $error("tdr_back: compare beyond clipped row");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
			result_valid_q && result_q.last |-> !pend_v_q)
		else $error("tdr_back: result held after last");

endmodule

/* hw/rtl/text_display_diff_refresh.sv */
// text_display_diff_refresh: top level of the differential character display refresh.
// Instantiates tdr_front and tdr_back; depends on tdr_pkg.
`timescale 1ns / 1ps

// Commands are transferred on start while busy is low and go through a two-entry
// queue, so busy rises only when the queue is full or the memories are being cleared.
// After reset the block sweeps both character grids to spaces, one cell per cycle,
// and holds busy high during the sweep; configuration writes are taken meanwhile.
// During a refresh the scan reads one cell of both grids per cycle through their
// single read port, pausing while each run found is read back from the wanted grid
// as the shadow is written. Results come one per cycle on result_valid with no flow
// control; the receiver must take every strobe, and last marks the final character
// of a refresh.
module text_display_diff_refresh #(
	parameter int ROWS = tdr_pkg::DEF_ROWS,
	parameter int COLS = tdr_pkg::DEF_COLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  tdr_pkg::tdr_cmd_t                cmd,
	output logic                             result_valid,
	output tdr_pkg::tdr_result_t             result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tdr_pkg::*;

	tdr_fwd_t            fwd;
	tdr_bstat_t          bstat;
	logic [GOTO_W-1:0]   gap_tol;

	// Intake, configuration and command queue
	tdr_front #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bstat     (bstat),
		.fwd       (fwd),
		.gap_tol   (gap_tol)
	);

	// Grid memories, region scan and result stream
	tdr_back #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fwd          (fwd),
		.bstat        (bstat),
		.gap_tol      (gap_tol),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
